>>> hdl/mlhs_pkg.sv
package mlhs_pkg;

	localparam int unsigned COUNT_BITS_DEF = 16;
	localparam int unsigned CFG_W          = 16;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned CMD_W          = 2;
	localparam int unsigned DRIVE_W        = 2;
	localparam int unsigned POS_W          = 2;
	localparam int unsigned EVENT_W        = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACK_OFF = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATE   = 2'd3;

	localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd3000;
	localparam logic [CFG_W-1:0] SETTLE_RST   = 16'd100;
	localparam logic [CFG_W-1:0] BACK_OFF_RST = 16'd200;
	localparam logic [CFG_W-1:0] ROTATE_RST   = 16'd500;

	localparam logic REQ_TICK    = 1'b0;
	localparam logic REQ_COMMAND = 1'b1;

	localparam logic DIR_CW  = 1'b0;
	localparam logic DIR_CCW = 1'b1;

	localparam logic [DRIVE_W-1:0] DRIVE_STOP = 2'd0;
	localparam logic [DRIVE_W-1:0] DRIVE_CW   = 2'd1;
	localparam logic [DRIVE_W-1:0] DRIVE_CCW  = 2'd2;

	localparam logic [POS_W-1:0] POS_UNKNOWN = 2'd0;
	localparam logic [POS_W-1:0] POS_CW      = 2'd1;
	localparam logic [POS_W-1:0] POS_CCW     = 2'd2;
	localparam logic [POS_W-1:0] POS_ERROR   = 2'd3;

	localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_THERE   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_BUSY    = 3'd2;
	localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd3;
	localparam logic [EVENT_W-1:0] EV_DONE    = 3'd4;

	function automatic logic [DRIVE_W-1:0] dir_drive(input logic dir);
		return (dir == DIR_CCW) ? DRIVE_CCW : DRIVE_CW;
	endfunction

	function automatic logic [POS_W-1:0] dir_pos(input logic dir);
		return (dir == DIR_CCW) ? POS_CCW : POS_CW;
	endfunction

endpackage

>>> hdl/motor_limit_homing_sequencer.sv
// Each transaction goes through the input register, then the result register.
// Throughput: one transaction per cycle, held back only by result_stall when both the
// input register and the result register are full.
// Reset (arst_n low, asynchronous): sequencer idle, drive stopped, position unknown,
// counter cleared, timing registers back at their defaults, both stages emptied.
module motor_limit_homing_sequencer #(
	parameter int unsigned COUNT_BITS = mlhs_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mlhs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mlhs_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             req_type,
	input  logic [mlhs_pkg::CMD_W-1:0]       command,
	input  logic                             limit_hit,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [mlhs_pkg::DRIVE_W-1:0]     motor_drive,
	output logic [mlhs_pkg::POS_W-1:0]       position,
	output logic                             busy_res,
	output logic [mlhs_pkg::EVENT_W-1:0]     event_res
);
	import mlhs_pkg::*;

	localparam int unsigned CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEEK,
		PH_SETTLE,
		PH_BACKOFF,
		PH_ROTATE
	} phase_t;

	logic [CFG_W-1:0] timeout_q, settle_q, back_off_q, rotate_q;

	logic               valid_s1;
	logic               req_type_s1;
	logic [CMD_W-1:0]   command_s1;
	logic               limit_hit_s1;

	phase_t                phase_q, phase_d;
	logic                  dir_q, dir_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [POS_W-1:0]      home_q, home_d;
	logic [EVENT_W-1:0]    ev_d;
	logic [DRIVE_W-1:0]    drive_d;

	logic                  advance;
	logic                  s1_load;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [CMP_W-1:0]      cnt_inc_w;

	assign advance    = !(result_valid && result_stall);
	assign s1_load    = advance || !valid_s1;
	assign item_stall = !s1_load;
	assign cnt_inc    = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign cnt_inc_w  = CMP_W'(cnt_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			settle_q   <= SETTLE_RST;
			back_off_q <= BACK_OFF_RST;
			rotate_q   <= ROTATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT:  timeout_q  <= cfg_data;
				CFG_SETTLE:   settle_q   <= cfg_data;
				CFG_BACK_OFF: back_off_q <= cfg_data;
				CFG_ROTATE:   rotate_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && item_valid) begin
			req_type_s1  <= req_type;
			command_s1   <= command;
			limit_hit_s1 <= limit_hit;
		end
	end

	always_comb begin
		phase_d = phase_q;
		dir_d   = dir_q;
		cnt_d   = cnt_q;
		home_d  = home_q;
		ev_d    = EV_NONE;
		if (req_type_s1 == REQ_COMMAND) begin
			if (phase_q != PH_IDLE) begin
				ev_d = EV_BUSY;
			end else if (home_q == dir_pos(command_s1[0])) begin
				ev_d = EV_THERE;
			end else begin
				dir_d = command_s1[0];
				cnt_d = '0;
				if (!command_s1[1]) begin
					phase_d = PH_SEEK;
				end else if (rotate_q == '0) begin
					ev_d = EV_DONE;
				end else begin
					phase_d = PH_ROTATE;
				end
			end
		end else begin
			unique case (phase_q)
				PH_SEEK: begin
					cnt_d = cnt_inc;
					if (cnt_inc_w >= CMP_W'(timeout_q)) begin
						phase_d = PH_IDLE;
						home_d  = POS_ERROR;
						ev_d    = EV_TIMEOUT;
					end else if (limit_hit_s1) begin
						cnt_d = '0;
						if (settle_q != '0) begin
							phase_d = PH_SETTLE;
						end else if (back_off_q != '0) begin
							phase_d = PH_BACKOFF;
						end else begin
							phase_d = PH_IDLE;
							home_d  = dir_pos(dir_q);
							ev_d    = EV_DONE;
						end
					end
				end
				PH_SETTLE: begin
					cnt_d = cnt_inc;
					if (cnt_inc_w >= CMP_W'(settle_q)) begin
						cnt_d = '0;
						if (back_off_q != '0) begin
							phase_d = PH_BACKOFF;
						end else begin
							phase_d = PH_IDLE;
							home_d  = dir_pos(dir_q);
							ev_d    = EV_DONE;
						end
					end
				end
				PH_BACKOFF: begin
					cnt_d = cnt_inc;
					if (cnt_inc_w >= CMP_W'(back_off_q)) begin
						phase_d = PH_IDLE;
						home_d  = dir_pos(dir_q);
						ev_d    = EV_DONE;
					end
				end
				PH_ROTATE: begin
					cnt_d = cnt_inc;
					if (cnt_inc_w >= CMP_W'(rotate_q)) begin
						phase_d = PH_IDLE;
						ev_d    = EV_DONE;
					end
				end
				default: ;
			endcase
		end
		unique case (phase_d)
			PH_SEEK, PH_ROTATE: drive_d = dir_drive(dir_d);
			PH_BACKOFF:         drive_d = dir_drive(!dir_d);
			default:            drive_d = DRIVE_STOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			dir_q        <= DIR_CW;
			cnt_q        <= '0;
			home_q       <= POS_UNKNOWN;
			result_valid <= 1'b0;
			motor_drive  <= DRIVE_STOP;
			position     <= POS_UNKNOWN;
			busy_res     <= 1'b0;
			event_res    <= EV_NONE;
		end else if (advance) begin
			result_valid <= valid_s1;
			if (valid_s1) begin
				phase_q     <= phase_d;
				dir_q       <= dir_d;
				cnt_q       <= cnt_d;
				home_q      <= home_d;
				motor_drive <= drive_d;
				position    <= home_d;
				busy_res    <= (phase_d != PH_IDLE);
				event_res   <= ev_d;
			end
		end
	end

endmodule
